[rtl/core/cia_pkg.sv]
// shared types, widths and codes for the complex impedance unit
// no dependencies; imported by cia_div and complex_impedance_alu
`default_nettype none

package cia_pkg;

    // default number of fraction bits of the operands
    localparam int unsigned CIA_FRAC_BITS = 16;

    // divider widths: numerator magnitude, denominator, quotient bits kept
    localparam int unsigned CIA_NUM_W   = 97;
    localparam int unsigned CIA_DEN_W   = 66;
    localparam int unsigned CIA_Q_W     = 33;
    // range check, one stage per quotient bit, clip stage
    localparam int unsigned CIA_DIV_LAT = CIA_Q_W + 2;

    localparam logic signed [31:0] CIA_MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CIA_MIN_VAL = 32'sh8000_0000;

    localparam logic [1:0] FUNC_SERIES   = 2'd0;
    localparam logic [1:0] FUNC_PARALLEL = 2'd1;
    localparam logic [1:0] FUNC_RECIP    = 2'd2;
    localparam logic [1:0] FUNC_SOURCE   = 2'd3;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
        logic signed [31:0] source_in;
    } cia_in_t;

    typedef struct packed {
        logic signed [31:0] result_real;
        logic signed [31:0] result_imag;
        logic signed [31:0] source_out;
        logic               degenerate;
        logic               saturated;
    } cia_out_t;

endpackage

`default_nettype wire

[rtl/core/cia_div.sv]
// pipelined restoring divider, one quotient bit per stage, clipped to 32 bits
// depends on cia_pkg for widths and limit values
`default_nettype none

module cia_div
    import cia_pkg::*;
(
    input  wire                      clk,
    input  wire                      num_neg,
    input  wire [CIA_NUM_W-1:0]      num_mag,
    input  wire [CIA_DEN_W-1:0]      den,
    output logic signed [31:0]       quo,
    output logic                     sat
);

    localparam int unsigned CW = CIA_DEN_W + CIA_Q_W;

    logic [CIA_NUM_W-1:0] rem_reg [0:CIA_Q_W];
    logic [CIA_Q_W-1:0]   q_reg   [0:CIA_Q_W];
    logic [CIA_DEN_W-1:0] den_reg [0:CIA_Q_W];
    logic                 neg_reg [0:CIA_Q_W];
    logic                 big_reg [0:CIA_Q_W];

    logic [CIA_NUM_W-1:0] rem_next [1:CIA_Q_W];
    logic [CIA_Q_W-1:0]   q_next   [1:CIA_Q_W];
    logic [CW:0]          diff     [1:CIA_Q_W];

    logic                 big_next;
    logic signed [31:0]   quo_next;
    logic                 sat_next;
    logic signed [31:0]   quo_reg;
    logic                 sat_reg;

    // quotient fits the kept bits only when num < den * 2^Q_W
    assign big_next = {{(CW-CIA_NUM_W){1'b0}}, num_mag}
                   >= ({{CIA_Q_W{1'b0}}, den} << CIA_Q_W);

    always_comb
    begin
        for (int k = 1; k <= CIA_Q_W; k++)
        begin
            diff[k] = {1'b0, {(CW-CIA_NUM_W){1'b0}}, rem_reg[k-1]}
                    - ({1'b0, {CIA_Q_W{1'b0}}, den_reg[k-1]} << (CIA_Q_W - k));
            q_next[k] = q_reg[k-1];
            q_next[k][CIA_Q_W-k] = ~diff[k][CW];
            rem_next[k] = diff[k][CW] ? rem_reg[k-1] : diff[k][CIA_NUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_mag;
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= num_neg;
        big_reg[0] <= big_next;
        for (int k = 1; k <= CIA_Q_W; k++)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
            den_reg[k] <= den_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            big_reg[k] <= big_reg[k-1];
        end
    end

    // clip magnitude and sign to the signed 32-bit range
    always_comb
    begin
        logic [CIA_Q_W-1:0] q;
        logic               pos_ovf;
        logic               neg_ovf;
        q = q_reg[CIA_Q_W];
        pos_ovf = big_reg[CIA_Q_W] || (q[CIA_Q_W-1:31] != '0);
        neg_ovf = big_reg[CIA_Q_W] || (q[CIA_Q_W-1:32] != '0)
               || (q[31] && (q[30:0] != 31'd0));
        if (neg_reg[CIA_Q_W])
        begin
            quo_next = neg_ovf ? CIA_MIN_VAL : -$signed(q[31:0]);
            sat_next = neg_ovf;
        end
        else
        begin
            quo_next = pos_ovf ? CIA_MAX_VAL : $signed(q[31:0]);
            sat_next = pos_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[rtl/core/complex_impedance_alu.sv]
// top level of the complex impedance unit: series, parallel, reciprocal, source transform
// depends on cia_pkg and cia_div
`default_nettype none

// Complex fixed-point unit for impedance work. A beat is taken on every
// clock edge with start high (busy is always low), one beat per cycle,
// and each beat gives exactly one result, marked by a one-cycle done
// strobe; results come out in the order the beats went in, and the
// receiver has no way to hold them off, so it must take every result as
// it appears. The pipeline is an eight-stage front end of multipliers and
// adders, then the two restoring dividers (one quotient bit per stage, 35
// stages with range check and clip), then two back stages for the source
// scaling and the output mux. zero_threshold is written over the cfg port
// (always ready); write it only while no beat is in flight. There is no
// clearing pass after reset.

module complex_impedance_alu
    import cia_pkg::*;
#(
    parameter int unsigned FRAC_BITS = CIA_FRAC_BITS
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    output logic         busy,
    input  wire cia_in_t operands,
    output logic         done,
    output cia_out_t     result,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [31:0]   cfg_data
);

    // stages from the bypass decision to the divider inputs
    localparam int unsigned FRONT      = 5;
    localparam int unsigned SIDE_DEPTH = FRONT + CIA_DIV_LAT;

    // what the back end needs to finish a beat
    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] src;
        logic               byp;
        logic signed [31:0] byp_rr;
        logic signed [31:0] byp_ri;
        logic               byp_deg;
        logic               byp_sat;
    } side_t;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] src;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic signed [63:0] sq_ar;
        logic signed [63:0] sq_ai;
        logic signed [63:0] sq_br;
        logic signed [63:0] sq_bi;
        logic signed [32:0] sr;
        logic signed [32:0] si;
        logic signed [31:0] ser_rr;
        logic signed [31:0] ser_ri;
        logic               ser_sat;
        logic               a_open;
        logic               b_open;
    } sa_t;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] src;
        logic signed [31:0] ser_rr;
        logic signed [31:0] ser_ri;
        logic               ser_sat;
        logic               a_open;
        logic               b_open;
        logic signed [64:0] pr;
        logic signed [64:0] pi;
        logic        [63:0] mag2a;
        logic        [63:0] mag2b;
        logic signed [32:0] sr;
        logic signed [32:0] si;
        logic signed [65:0] sr2;
        logic signed [65:0] si2;
    } sb_t;

    typedef struct packed {
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic        [63:0]  prm;
        logic        [63:0]  pim;
        logic        [32:0]  srm;
        logic        [32:0]  sim;
        logic        [3:0]   sgn;
        logic [CIA_DEN_W-1:0] den;
    } sc_t;

    typedef struct packed {
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic        [64:0]  pp_rl;
        logic        [64:0]  pp_rh;
        logic        [64:0]  pp_ii_l;
        logic        [64:0]  pp_ii_h;
        logic        [64:0]  pp_ir_l;
        logic        [64:0]  pp_ir_h;
        logic        [64:0]  pp_ri_l;
        logic        [64:0]  pp_ri_h;
        logic        [3:0]   sgn;
        logic [CIA_DEN_W-1:0] den;
    } sd_t;

    typedef struct packed {
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic        [96:0]  t1;
        logic        [96:0]  t2;
        logic        [96:0]  t3;
        logic        [96:0]  t4;
        logic        [3:0]   sgn;
        logic [CIA_DEN_W-1:0] den;
    } se_t;

    typedef struct packed {
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic signed [98:0]  st1;
        logic signed [98:0]  st2;
        logic signed [98:0]  st3;
        logic signed [98:0]  st4;
        logic [CIA_DEN_W-1:0] den;
    } sf_t;

    typedef struct packed {
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic signed [98:0]  nr;
        logic signed [98:0]  ni;
        logic [CIA_DEN_W-1:0] den;
    } sg_t;

    logic        [31:0] thr_reg;

    logic               a_v_reg, b_v_reg, c_v_reg;
    sa_t                a_reg, a_next;
    sb_t                b_reg, b_next;
    sc_t                c_reg, c_next;
    side_t              side_c_reg, side_c_next;
    sd_t                d_reg, d_next;
    se_t                e_reg, e_next;
    sf_t                f_reg, f_next;
    sg_t                g_reg, g_next;

    logic [SIDE_DEPTH-1:0] v_line_reg;
    side_t              side_line_reg [0:SIDE_DEPTH-1];

    // divider inputs
    logic               kr_neg_reg, ki_neg_reg, kr_neg_next, ki_neg_next;
    logic [CIA_NUM_W-1:0] kr_mag_reg, ki_mag_reg, kr_mag_next, ki_mag_next;
    logic [CIA_DEN_W-1:0] k_den_reg;

    logic signed [31:0] quo_r, quo_i;
    logic               sat_r, sat_i;

    logic               h_v_reg;
    side_t              h_side_reg;
    logic signed [31:0] h_rr_reg, h_ri_reg;
    logic               h_sat_reg;
    logic signed [63:0] h_p_reg, h_p_next;

    logic               done_reg;
    cia_out_t           result_reg, result_next;

    // the pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // stage a: products, squares, operand sums, series result
    always_comb
    begin
        logic signed [32:0] ss_r;
        logic signed [32:0] ss_i;
        a_next.func  = operands.func;
        a_next.ar    = operands.a_real;
        a_next.ai    = operands.a_imag;
        a_next.br    = operands.b_real;
        a_next.bi    = operands.b_imag;
        a_next.src   = operands.source_in;
        a_next.p_rr  = operands.a_real * operands.b_real;
        a_next.p_ii  = operands.a_imag * operands.b_imag;
        a_next.p_ri  = operands.a_real * operands.b_imag;
        a_next.p_ir  = operands.a_imag * operands.b_real;
        a_next.sq_ar = operands.a_real * operands.a_real;
        a_next.sq_ai = operands.a_imag * operands.a_imag;
        a_next.sq_br = operands.b_real * operands.b_real;
        a_next.sq_bi = operands.b_imag * operands.b_imag;
        ss_r = 33'(operands.a_real) + 33'(operands.b_real);
        ss_i = 33'(operands.a_imag) + 33'(operands.b_imag);
        a_next.sr = ss_r;
        a_next.si = ss_i;
        // a sum out of range shows as differing top two bits
        a_next.ser_rr = (ss_r[32] != ss_r[31])
                      ? (ss_r[32] ? CIA_MIN_VAL : CIA_MAX_VAL) : ss_r[31:0];
        a_next.ser_ri = (ss_i[32] != ss_i[31])
                      ? (ss_i[32] ? CIA_MIN_VAL : CIA_MAX_VAL) : ss_i[31:0];
        a_next.ser_sat = (ss_r[32] != ss_r[31]) || (ss_i[32] != ss_i[31]);
        a_next.a_open  = (operands.a_real == CIA_MAX_VAL);
        a_next.b_open  = (operands.b_real == CIA_MAX_VAL);
    end

    // stage b: products of the operands, squared magnitudes, squares of the sum
    always_comb
    begin
        b_next.func    = a_reg.func;
        b_next.ar      = a_reg.ar;
        b_next.ai      = a_reg.ai;
        b_next.br      = a_reg.br;
        b_next.bi      = a_reg.bi;
        b_next.src     = a_reg.src;
        b_next.ser_rr  = a_reg.ser_rr;
        b_next.ser_ri  = a_reg.ser_ri;
        b_next.ser_sat = a_reg.ser_sat;
        b_next.a_open  = a_reg.a_open;
        b_next.b_open  = a_reg.b_open;
        b_next.pr      = 65'(a_reg.p_rr) - 65'(a_reg.p_ii);
        b_next.pi      = 65'(a_reg.p_ri) + 65'(a_reg.p_ir);
        b_next.mag2a   = $unsigned(a_reg.sq_ar) + $unsigned(a_reg.sq_ai);
        b_next.mag2b   = $unsigned(a_reg.sq_br) + $unsigned(a_reg.sq_bi);
        b_next.sr      = a_reg.sr;
        b_next.si      = a_reg.si;
        b_next.sr2     = a_reg.sr * a_reg.sr;
        b_next.si2     = a_reg.si * a_reg.si;
    end

    // stage c: zero tests, special cases, magnitudes and signs for the numerator
    always_comb
    begin
        logic [CIA_DEN_W-1:0] d_par;
        logic                 za, zb, zs;
        logic signed [64:0]   pr_abs, pi_abs;
        logic signed [32:0]   sr_abs, si_abs;
        logic                 prn, pin, srn, sin_n;
        d_par = $unsigned(b_reg.sr2) + $unsigned(b_reg.si2);
        za = (b_reg.mag2a == 64'd0) || (b_reg.mag2a < {32'd0, thr_reg});
        zb = (b_reg.mag2b == 64'd0) || (b_reg.mag2b < {32'd0, thr_reg});
        zs = (d_par == '0) || (d_par < {{(CIA_DEN_W-32){1'b0}}, thr_reg});
        prn   = b_reg.pr[64];
        pin   = b_reg.pi[64];
        srn   = b_reg.sr[32];
        sin_n = b_reg.si[32];
        pr_abs = prn   ? -b_reg.pr : b_reg.pr;
        pi_abs = pin   ? -b_reg.pi : b_reg.pi;
        sr_abs = srn   ? -b_reg.sr : b_reg.sr;
        si_abs = sin_n ? -b_reg.si : b_reg.si;

        c_next.ar  = b_reg.ar;
        c_next.ai  = b_reg.ai;
        c_next.prm = pr_abs[63:0];
        c_next.pim = pi_abs[63:0];
        c_next.srm = sr_abs;
        c_next.sim = si_abs;
        // numerator term signs: pr*sr, pi*si, pi*sr, pr*si
        c_next.sgn = {prn ^ sin_n, pin ^ srn, pin ^ sin_n, prn ^ srn};
        c_next.den = (b_reg.func == FUNC_PARALLEL)
                   ? d_par : {{(CIA_DEN_W-64){1'b0}}, b_reg.mag2a};

        side_c_next.func    = b_reg.func;
        side_c_next.src     = b_reg.src;
        side_c_next.byp     = 1'b0;
        side_c_next.byp_rr  = '0;
        side_c_next.byp_ri  = '0;
        side_c_next.byp_deg = 1'b0;
        side_c_next.byp_sat = 1'b0;
        unique case (b_reg.func) inside
            FUNC_SERIES:
            begin
                side_c_next.byp     = 1'b1;
                side_c_next.byp_rr  = b_reg.ser_rr;
                side_c_next.byp_ri  = b_reg.ser_ri;
                side_c_next.byp_sat = b_reg.ser_sat;
            end
            FUNC_PARALLEL:
            begin
                if (za || zb)
                begin
                    // short across either branch
                    side_c_next.byp = 1'b1;
                end
                else if (b_reg.a_open)
                begin
                    side_c_next.byp    = 1'b1;
                    side_c_next.byp_rr = b_reg.br;
                    side_c_next.byp_ri = b_reg.bi;
                end
                else if (b_reg.b_open)
                begin
                    side_c_next.byp    = 1'b1;
                    side_c_next.byp_rr = b_reg.ar;
                    side_c_next.byp_ri = b_reg.ai;
                end
                else if (zs)
                begin
                    side_c_next.byp     = 1'b1;
                    side_c_next.byp_rr  = CIA_MAX_VAL;
                    side_c_next.byp_deg = 1'b1;
                end
            end
            FUNC_RECIP, FUNC_SOURCE:
            begin
                if (za)
                begin
                    side_c_next.byp     = 1'b1;
                    side_c_next.byp_rr  = CIA_MAX_VAL;
                    side_c_next.byp_deg = 1'b1;
                end
            end
        endcase
    end

    // stage d: 64 x 33 products split into 32 x 33 partial products
    always_comb
    begin
        d_next.ar      = c_reg.ar;
        d_next.ai      = c_reg.ai;
        d_next.pp_rl   = 65'(c_reg.prm[31:0])  * 65'(c_reg.srm);
        d_next.pp_rh   = 65'(c_reg.prm[63:32]) * 65'(c_reg.srm);
        d_next.pp_ii_l = 65'(c_reg.pim[31:0])  * 65'(c_reg.sim);
        d_next.pp_ii_h = 65'(c_reg.pim[63:32]) * 65'(c_reg.sim);
        d_next.pp_ir_l = 65'(c_reg.pim[31:0])  * 65'(c_reg.srm);
        d_next.pp_ir_h = 65'(c_reg.pim[63:32]) * 65'(c_reg.srm);
        d_next.pp_ri_l = 65'(c_reg.prm[31:0])  * 65'(c_reg.sim);
        d_next.pp_ri_h = 65'(c_reg.prm[63:32]) * 65'(c_reg.sim);
        d_next.sgn     = c_reg.sgn;
        d_next.den     = c_reg.den;
    end

    // stage e: recombine partial products
    always_comb
    begin
        e_next.ar  = d_reg.ar;
        e_next.ai  = d_reg.ai;
        e_next.t1  = (97'(d_reg.pp_rh)   << 32) + 97'(d_reg.pp_rl);
        e_next.t2  = (97'(d_reg.pp_ii_h) << 32) + 97'(d_reg.pp_ii_l);
        e_next.t3  = (97'(d_reg.pp_ir_h) << 32) + 97'(d_reg.pp_ir_l);
        e_next.t4  = (97'(d_reg.pp_ri_h) << 32) + 97'(d_reg.pp_ri_l);
        e_next.sgn = d_reg.sgn;
        e_next.den = d_reg.den;
    end

    // stage f: apply term signs
    always_comb
    begin
        logic signed [98:0] x1, x2, x3, x4;
        x1 = $signed({2'b00, e_reg.t1});
        x2 = $signed({2'b00, e_reg.t2});
        x3 = $signed({2'b00, e_reg.t3});
        x4 = $signed({2'b00, e_reg.t4});
        f_next.ar  = e_reg.ar;
        f_next.ai  = e_reg.ai;
        f_next.st1 = e_reg.sgn[0] ? -x1 : x1;
        f_next.st2 = e_reg.sgn[1] ? -x2 : x2;
        f_next.st3 = e_reg.sgn[2] ? -x3 : x3;
        f_next.st4 = e_reg.sgn[3] ? -x4 : x4;
        f_next.den = e_reg.den;
    end

    // stage g: numerator of (a*b) * conj(a+b)
    always_comb
    begin
        g_next.ar  = f_reg.ar;
        g_next.ai  = f_reg.ai;
        g_next.nr  = f_reg.st1 + f_reg.st2;
        g_next.ni  = f_reg.st3 - f_reg.st4;
        g_next.den = f_reg.den;
    end

    // stage k: sign and magnitude for the dividers, reciprocal numerators muxed in
    always_comb
    begin
        logic signed [98:0] nr_abs, ni_abs;
        logic        [31:0] ar_mag, ai_mag;
        nr_abs = g_reg.nr[98] ? -g_reg.nr : g_reg.nr;
        ni_abs = g_reg.ni[98] ? -g_reg.ni : g_reg.ni;
        ar_mag = g_reg.ar[31] ? (~$unsigned(g_reg.ar) + 32'd1) : $unsigned(g_reg.ar);
        ai_mag = g_reg.ai[31] ? (~$unsigned(g_reg.ai) + 32'd1) : $unsigned(g_reg.ai);
        if (side_line_reg[FRONT-2].func == FUNC_PARALLEL)
        begin
            kr_neg_next = g_reg.nr[98];
            ki_neg_next = g_reg.ni[98];
            kr_mag_next = nr_abs[CIA_NUM_W-1:0];
            ki_mag_next = ni_abs[CIA_NUM_W-1:0];
        end
        else
        begin
            // conj(a) / |a|^2 scaled up by 2 * FRAC_BITS
            kr_neg_next = g_reg.ar[31];
            ki_neg_next = !g_reg.ai[31] && (g_reg.ai != 32'sd0);
            kr_mag_next = {{(CIA_NUM_W-32){1'b0}}, ar_mag} << (2 * FRAC_BITS);
            ki_mag_next = {{(CIA_NUM_W-32){1'b0}}, ai_mag} << (2 * FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            c_v_reg    <= 1'b0;
            v_line_reg <= '0;
            h_v_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            a_v_reg    <= start && !busy;
            b_v_reg    <= a_v_reg;
            c_v_reg    <= b_v_reg;
            v_line_reg <= {v_line_reg[SIDE_DEPTH-2:0], c_v_reg};
            h_v_reg    <= v_line_reg[SIDE_DEPTH-1];
            done_reg   <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        side_c_reg <= side_c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        f_reg      <= f_next;
        g_reg      <= g_next;
        kr_neg_reg <= kr_neg_next;
        ki_neg_reg <= ki_neg_next;
        kr_mag_reg <= kr_mag_next;
        ki_mag_reg <= ki_mag_next;
        k_den_reg  <= g_reg.den;
        side_line_reg[0] <= side_c_reg;
        for (int j = 1; j < SIDE_DEPTH; j++)
        begin
            side_line_reg[j] <= side_line_reg[j-1];
        end
    end

    cia_div u_div_real (
        .clk     (clk),
        .num_neg (kr_neg_reg),
        .num_mag (kr_mag_reg),
        .den     (k_den_reg),
        .quo     (quo_r),
        .sat     (sat_r)
    );

    cia_div u_div_imag (
        .clk     (clk),
        .num_neg (ki_neg_reg),
        .num_mag (ki_mag_reg),
        .den     (k_den_reg),
        .quo     (quo_i),
        .sat     (sat_i)
    );

    // stage h: source scaled by the clipped real part of the reciprocal
    assign h_p_next = side_line_reg[SIDE_DEPTH-1].src * quo_r;

    always_ff @(posedge clk)
    begin
        h_side_reg <= side_line_reg[SIDE_DEPTH-1];
        h_rr_reg   <= quo_r;
        h_ri_reg   <= quo_i;
        h_sat_reg  <= sat_r || sat_i;
        h_p_reg    <= h_p_next;
    end

    // output stage: truncate source toward zero, clip, pick bypass or quotient
    always_comb
    begin
        logic [63:0] pm;
        logic [63:0] m;
        logic        pos_ovf, neg_ovf, so_sat;
        logic signed [31:0] so;
        pm = h_p_reg[63] ? (~$unsigned(h_p_reg) + 64'd1) : $unsigned(h_p_reg);
        m  = pm >> FRAC_BITS;
        pos_ovf = (m[63:31] != '0);
        neg_ovf = (m[63:32] != '0) || (m[31] && (m[30:0] != 31'd0));
        if (h_p_reg[63])
        begin
            so     = neg_ovf ? CIA_MIN_VAL : -$signed(m[31:0]);
            so_sat = neg_ovf;
        end
        else
        begin
            so     = pos_ovf ? CIA_MAX_VAL : $signed(m[31:0]);
            so_sat = pos_ovf;
        end

        if (h_side_reg.byp)
        begin
            result_next.result_real = h_side_reg.byp_rr;
            result_next.result_imag = h_side_reg.byp_ri;
            result_next.source_out  = '0;
            result_next.degenerate  = h_side_reg.byp_deg;
            result_next.saturated   = h_side_reg.byp_sat;
        end
        else if (h_side_reg.func == FUNC_SOURCE)
        begin
            result_next.result_real = h_rr_reg;
            result_next.result_imag = h_ri_reg;
            result_next.source_out  = so;
            result_next.degenerate  = 1'b0;
            result_next.saturated   = h_sat_reg || so_sat;
        end
        else
        begin
            result_next.result_real = h_rr_reg;
            result_next.result_imag = h_ri_reg;
            result_next.source_out  = '0;
            result_next.degenerate  = 1'b0;
            result_next.saturated   = h_sat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a forced open value never comes with clipping or a source value
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |-> result.result_real == CIA_MAX_VAL
            && result.result_imag == 32'sd0 && result.source_out == 32'sd0
            && !result.saturated)
        else $error("degenerate result is not the open value");

    // the strobe follows the divider output by the two back stages
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v_line_reg[SIDE_DEPTH-1], 2))
        else $error("result strobe without a beat leaving the dividers");

    // source value only for the source transform
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result.source_out != 32'sd0) |->
            $past(h_side_reg.func) == FUNC_SOURCE && !$past(h_side_reg.byp))
        else $error("source value out of a beat that is no source transform");

endmodule

`default_nettype wire

[tb/sv/tb_complex_impedance_alu.sv]
// self-checking bench for complex_impedance_alu: directed corners, then random beats
// depends on cia_pkg and the complex_impedance_alu rtl
`timescale 1ns / 100ps

module tb_complex_impedance_alu;
    import cia_pkg::*;

    localparam int unsigned FB = CIA_FRAC_BITS;

    // predicts each result from the operands and the current threshold, and
    // keeps the expected results in the order the beats went in
    class impedance_ledger;
        cia_out_t    expected_q[$];
        logic [31:0] zero_thr = 32'd1;
        int          n_bad = 0;

        function logic signed [31:0] clip_mag(bit neg, bit big, logic [63:0] m,
                                              inout bit sat);
            if (!neg)
            begin
                if (big || m > 64'h7FFF_FFFF)
                begin
                    sat = 1'b1;
                    return CIA_MAX_VAL;
                end
                return m[31:0];
            end
            if (big || m > 64'h8000_0000)
            begin
                sat = 1'b1;
                return CIA_MIN_VAL;
            end
            return -m[31:0];
        endfunction

        function logic [127:0] mag_sq(logic signed [63:0] x, logic signed [63:0] y);
            logic signed [127:0] xw, yw;
            xw = x;
            yw = y;
            return xw * xw + yw * yw;
        endfunction

        function bit is_zero(logic [127:0] m);
            return m[127:64] == 0 && (m[63:0] == 0 || m[63:0] < {32'd0, zero_thr});
        endfunction

        // truncating division of a signed numerator by a positive denominator
        function logic signed [31:0] quot(logic signed [127:0] num, logic [127:0] den,
                                          inout bit sat);
            logic [127:0] n, q;
            n = num[127] ? -num : num;
            q = n / den;
            return clip_mag(num[127], q[127:64] != 0, q[63:0], sat);
        endfunction

        function cia_out_t impedance_of(cia_in_t x);
            cia_out_t            r;
            logic signed [63:0]  ar, ai, br, bi, sr, si, v, p, s64, r64;
            logic signed [127:0] aw, aiw, bw, biw, srw, siw, pr, pi;
            logic [127:0]        d;
            bit                  sat;
            r   = '0;
            sat = 1'b0;
            ar  = x.a_real;
            ai  = x.a_imag;
            br  = x.b_real;
            bi  = x.b_imag;
            case (x.func)
                FUNC_SERIES:
                begin
                    v = ar + br;
                    r.result_real = clip_mag(v < 0, 1'b0, v < 0 ? -v : v, sat);
                    v = ai + bi;
                    r.result_imag = clip_mag(v < 0, 1'b0, v < 0 ? -v : v, sat);
                end
                FUNC_PARALLEL:
                begin
                    if (is_zero(mag_sq(ar, ai)) || is_zero(mag_sq(br, bi)))
                    begin
                        r.result_real = '0;
                    end
                    else if (x.a_real == CIA_MAX_VAL)
                    begin
                        r.result_real = x.b_real;
                        r.result_imag = x.b_imag;
                    end
                    else if (x.b_real == CIA_MAX_VAL)
                    begin
                        r.result_real = x.a_real;
                        r.result_imag = x.a_imag;
                    end
                    else
                    begin
                        sr = ar + br;
                        si = ai + bi;
                        d  = mag_sq(sr, si);
                        if (is_zero(d))
                        begin
                            r.result_real = CIA_MAX_VAL;
                            r.degenerate  = 1'b1;
                        end
                        else
                        begin
                            aw  = ar;
                            aiw = ai;
                            bw  = br;
                            biw = bi;
                            srw = sr;
                            siw = si;
                            pr  = aw * bw - aiw * biw;
                            pi  = aw * biw + aiw * bw;
                            r.result_real = quot(pr * srw + pi * siw, d, sat);
                            r.result_imag = quot(pi * srw - pr * siw, d, sat);
                        end
                    end
                end
                default:
                begin
                    // reciprocal, and the source transform on top of it
                    d = mag_sq(ar, ai);
                    if (is_zero(d))
                    begin
                        r.result_real = CIA_MAX_VAL;
                        r.degenerate  = 1'b1;
                    end
                    else
                    begin
                        aw  = ar;
                        aiw = ai;
                        r.result_real = quot(aw <<< (2 * FB), d, sat);
                        r.result_imag = quot(-(aiw <<< (2 * FB)), d, sat);
                        if (x.func == FUNC_SOURCE)
                        begin
                            s64 = x.source_in;
                            r64 = r.result_real;
                            p   = s64 * r64;
                            r.source_out = clip_mag(p < 0, 1'b0, (p < 0 ? -p : p) >> FB, sat);
                        end
                    end
                end
            endcase
            r.saturated = sat;
            return r;
        endfunction

        function void note(cia_in_t x);
            expected_q.push_back(impedance_of(x));
        endfunction

        function void check(cia_out_t got);
            cia_out_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                n_bad++;
                return;
            end
            e = expected_q.pop_front();
            if (got.result_real !== e.result_real)
            begin
                $error("result_real expected %h actual %h", e.result_real, got.result_real);
                n_bad++;
            end
            if (got.result_imag !== e.result_imag)
            begin
                $error("result_imag expected %h actual %h", e.result_imag, got.result_imag);
                n_bad++;
            end
            if (got.source_out !== e.source_out)
            begin
                $error("source_out expected %h actual %h", e.source_out, got.source_out);
                n_bad++;
            end
            if (got.degenerate !== e.degenerate)
            begin
                $error("degenerate expected %b actual %b", e.degenerate, got.degenerate);
                n_bad++;
            end
            if (got.saturated !== e.saturated)
            begin
                $error("saturated expected %b actual %b", e.saturated, got.saturated);
                n_bad++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    cia_in_t     operands;
    logic        done;
    cia_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    impedance_ledger ledger = new();
    int unsigned     n_taken = 0;
    int unsigned     n_cfg = 0;

    always #5 clk = ~clk;

    complex_impedance_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operands  (operands),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // everything is sampled on the rising edge; inputs move on the falling edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                ledger.note(operands);
                n_taken++;
            end
            if (done)
                ledger.check(result);
            if (cfg_valid && cfg_ready)
            begin
                ledger.zero_thr = cfg_data;
                n_cfg++;
            end
        end
    end

    // offers one beat, with an optional idle burst first; start stays high after
    task automatic send_beat(cia_in_t x, bit may_idle);
        int unsigned k;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        operands = x;
        start    = 1'b1;
        k        = n_taken;
        do
            @(negedge clk);
        while (n_taken == k);
    endtask

    // lets the pipe drain, then writes the threshold register
    task automatic write_threshold(logic [31:0] v);
        int unsigned k;
        start = 1'b0;
        while (ledger.expected_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        cfg_data  = v;
        cfg_valid = 1'b1;
        k         = n_cfg;
        do
            @(negedge clk);
        while (n_cfg == k);
        cfg_valid = 1'b0;
    endtask

    // operand part biased toward the corners and toward small values
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            3:       return $urandom_range(0, 15) - 8;
            4, 5:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cia_in_t pick_beat();
        cia_in_t x;
        x.func      = 2'($urandom_range(0, 3));
        x.a_real    = pick_part();
        x.a_imag    = pick_part();
        x.b_real    = pick_part();
        x.b_imag    = pick_part();
        x.source_in = ($urandom_range(0, 3) == 0) ? pick_part() : $urandom;
        // near-cancelling sum for the parallel case
        if (x.func == FUNC_PARALLEL && $urandom_range(0, 4) == 0)
        begin
            x.b_real = -x.a_real + ($urandom_range(0, 3) - 1);
            x.b_imag = -x.a_imag + ($urandom_range(0, 3) - 1);
        end
        return x;
    endfunction

    function automatic cia_in_t mk(logic [1:0] f, logic [31:0] ar, logic [31:0] ai,
                                   logic [31:0] br, logic [31:0] bi, logic [31:0] s);
        cia_in_t x;
        x.func      = f;
        x.a_real    = ar;
        x.a_imag    = ai;
        x.b_real    = br;
        x.b_imag    = bi;
        x.source_in = s;
        return x;
    endfunction

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MX  = 32'h7FFF_FFFF;
    localparam logic [31:0] MN  = 32'h8000_0000;

    initial
    begin
        cia_in_t dirs[$];
        logic [31:0] thr_list[4];
        rst_n     = 1'b0;
        start     = 1'b0;
        operands  = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners under the reset threshold
        dirs = '{
            mk(FUNC_SERIES,   MX, MX, MX, MX, 0),                 // positive clip
            mk(FUNC_SERIES,   MN, MN, MN, MN, 0),                 // negative clip
            mk(FUNC_SERIES,   ONE, -ONE, 3, 32'hFFFF_FFF0, MX),
            mk(FUNC_PARALLEL, 0, 0, ONE, ONE, 0),                 // zero first operand
            mk(FUNC_PARALLEL, ONE, 0, 0, 0, 0),                   // zero second operand
            mk(FUNC_PARALLEL, MX, 5, ONE, -ONE, 0),               // open first operand
            mk(FUNC_PARALLEL, ONE, 7, MX, 9, 0),                  // open second operand
            mk(FUNC_PARALLEL, ONE, ONE, -ONE, -ONE, 0),           // zero sum
            mk(FUNC_PARALLEL, 2 * ONE, ONE, 3 * ONE, -ONE, 0),
            mk(FUNC_PARALLEL, MN, MN, MN, MN, 0),
            mk(FUNC_RECIP,    0, 0, MX, MX, MX),                  // zero operand
            mk(FUNC_RECIP,    1, 0, 0, 0, 0),                     // tiny operand clips
            mk(FUNC_RECIP,    MN, MN, 0, 0, 0),
            mk(FUNC_RECIP,    MX, -ONE, 0, 0, 0),
            mk(FUNC_SOURCE,   0, 0, 0, 0, MX),                    // zero operand
            mk(FUNC_SOURCE,   ONE, 0, 0, 0, MX),
            mk(FUNC_SOURCE,   16, 0, 0, 0, MN),                   // scaled source clips
            mk(FUNC_SOURCE,   -2 * ONE, ONE, 0, 0, -12345),
            mk(FUNC_SOURCE,   MN, 0, 0, 0, 32'h8000_0001)
        };
        foreach (dirs[i])
            send_beat(dirs[i], 1'b1);
        for (int i = 0; i < 260; i++)
            send_beat(pick_beat(), 1'b1);

        // further phases: extremes of the threshold, a random one, then back to one
        thr_list = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1};
        foreach (thr_list[p])
        begin
            write_threshold(thr_list[p]);
            for (int i = 0; i < 210; i++)
                send_beat(pick_beat(), p != 3);
        end
        start = 1'b0;

        while (ledger.expected_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (ledger.n_bad == 0 && ledger.expected_q.size() == 0)
            $display("complex_impedance_alu: match");
        else
            $display("complex_impedance_alu: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("complex_impedance_alu: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cia_pkg.sv
rtl/core/cia_div.sv
rtl/core/complex_impedance_alu.sv
tb/sv/tb_complex_impedance_alu.sv
